// File: rtl/ssrf_pkg.sv
// shared types and constants for the slot status ring fifo
package ssrf_pkg;

  localparam int CMD_W      = 2;
  localparam int PAYLOAD_W  = 32;
  localparam int SLOT_W     = 10;
  localparam int TIME_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int SSTATE_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SIU_W      = 11;
  localparam int CNT16_W    = 16;

  // request commands
  localparam logic [CMD_W-1:0] CMD_OFFER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DONE  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] STS_IGNORED = 2'd3;

  // per-slot states
  localparam logic [SSTATE_W-1:0] SS_PENDING  = 2'd0;
  localparam logic [SSTATE_W-1:0] SS_CONSUMED = 2'd1;
  localparam logic [SSTATE_W-1:0] SS_FREE     = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTIFY_BATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd2;

  localparam logic [SIU_W-1:0]   RST_SLOTS_IN_USE = 11'd1024;
  localparam logic [CNT16_W-1:0] RST_NOTIFY_BATCH = 16'd100;
  localparam logic [CNT16_W-1:0] RST_MIN_INTERVAL = 16'd10;
  localparam logic [CNT16_W-1:0] PEND_MAX         = 16'hFFFF;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [PAYLOAD_W-1:0] payload;
    logic [SLOT_W-1:0]    slot;
    logic [TIME_W-1:0]    now_ms;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] payload_res;
    logic [SLOT_W-1:0]    slot_res;
    logic [SSTATE_W-1:0]  slot_state;
    logic                 notify;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CLEAN_RD,
    S_CLEAN_EV,
    S_PROD_RD,
    S_PROD_EV,
    S_CONS_RD,
    S_CONS_EV,
    S_SLOT_RD,
    S_SLOT_EV,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    RA_CLEAN,
    RA_PROD,
    RA_CONS,
    RA_SLOT
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    clear_wr;
    logic    clean_step;
    logic    cons_step;
    logic    offer_fin;
    logic    take_fin;
    logic    done_fin;
    logic    query_fin;
    rd_sel_t rd_sel;
  } ctl_t;

  typedef struct packed {
    logic             clean_more;
    logic             cons_more;
    logic             clear_last;
    logic [CMD_W-1:0] cmd;
  } dp_stat_t;

endpackage

// File: rtl/slot_status_ring_fifo.sv
// top level of the slot status ring fifo
// offer: walks clean_ptr, freeing consumed slots, then checks the prod_ptr slot
// take: walks cons_ptr past consumed slots; done and query read req.slot
// each walk step is a read state then an evaluate state on the slot state ram
// reset clears the slot state ram, one slot a cycle, with busy high
// the result is shown for one cycle on result_valid; the receiver cannot stall
module slot_status_ring_fifo #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  ssrf_pkg::req_t                      req,
  output logic                                result_valid,
  output ssrf_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssrf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ssrf_pkg::*;

  ctl_t     ctl;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ssrf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (req.command),
    .stat         (stat),
    .busy         (busy),
    .result_valid (result_valid),
    .ctl          (ctl)
  );

  ssrf_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .req       (req),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .result    (result)
  );

endmodule

// File: rtl/ssrf_ram.sv
// generic single write port ram with registered read
module ssrf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/ssrf_datapath.sv
// pointers, counters, slot memories, notification logic and result register
module ssrf_datapath #(
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ssrf_pkg::ctl_t                      ctl,
  input  ssrf_pkg::req_t                      req,
  input  logic                                cfg_valid,
  input  logic [ssrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssrf_pkg::CFG_DATA_W-1:0]     cfg_data,
  output ssrf_pkg::dp_stat_t                  stat,
  output ssrf_pkg::result_t                   result
);
  import ssrf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [SIU_W-1:0]   slots_in_use;
  logic [CNT16_W-1:0] notify_batch;
  logic [CNT16_W-1:0] min_interval;

  logic [PW-1:0]      clean_ptr;
  logic [PW-1:0]      prod_ptr;
  logic [PW-1:0]      cons_ptr;
  logic [PW-1:0]      clr_cnt;
  logic [NW-1:0]      walk_cnt;
  logic [CNT16_W-1:0] pend_writes;
  logic [TIME_W-1:0]  last_time;
  logic               interval_ok;
  req_t               req_q;

  logic [NW-1:0]      ring_n;
  logic [PW-1:0]      slot_addr;
  logic               slot_in;

  logic               st_we;
  logic [PW-1:0]      st_waddr;
  logic [SSTATE_W-1:0] st_wdata;
  logic [PW-1:0]      st_raddr;
  logic [SSTATE_W-1:0] st_rdata;
  logic               pl_we;
  logic [PAYLOAD_W-1:0] pl_rdata;

  logic               stored;
  logic [CNT16_W-1:0] pend_inc;
  logic               fire;
  logic               any_fin;
  result_t            result_next;

  function automatic logic [PW-1:0] adv_ptr(input logic [PW-1:0] p, input logic [NW-1:0] n);
    logic [NW:0] s;
    s = (NW+1)'(p) + (NW+1)'(1);
    return (s >= (NW+1)'(n)) ? '0 : PW'(s);
  endfunction

  function automatic logic [PW-1:0] fix_ptr(input logic [PW-1:0] p, input logic [NW-1:0] n);
    return (NW'(p) >= n) ? '0 : p;
  endfunction

  // ring size clamped to 1..DEPTH
  always_comb begin
    if (slots_in_use == '0) begin
      ring_n = NW'(1);
    end else if (32'(slots_in_use) > 32'(DEPTH)) begin
      ring_n = NW'(DEPTH);
    end else begin
      ring_n = NW'(slots_in_use);
    end
  end

  assign slot_addr = PW'(req_q.slot);
  assign slot_in   = 32'(req_q.slot) < 32'(ring_n);

  always_comb begin
    case (ctl.rd_sel)
      RA_CLEAN: st_raddr = clean_ptr;
      RA_PROD:  st_raddr = prod_ptr;
      RA_CONS:  st_raddr = cons_ptr;
      RA_SLOT:  st_raddr = slot_addr;
      default:  st_raddr = slot_addr;
    endcase
  end

  assign stored = ctl.offer_fin && (st_rdata == SS_FREE);

  always_comb begin
    st_we    = 1'b0;
    st_waddr = clean_ptr;
    st_wdata = SS_FREE;
    if (ctl.clear_wr) begin
      st_we    = 1'b1;
      st_waddr = clr_cnt;
    end else if (ctl.clean_step) begin
      st_we    = 1'b1;
      st_waddr = clean_ptr;
    end else if (stored) begin
      st_we    = 1'b1;
      st_waddr = prod_ptr;
      st_wdata = SS_PENDING;
    end else if (ctl.done_fin && slot_in && st_rdata == SS_PENDING) begin
      st_we    = 1'b1;
      st_waddr = slot_addr;
      st_wdata = SS_CONSUMED;
    end
  end

  assign pl_we = stored;

  ssrf_ram #(.WIDTH(SSTATE_W), .DEPTH(DEPTH)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  ssrf_ram #(.WIDTH(PAYLOAD_W), .DEPTH(DEPTH)) u_payload_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (prod_ptr),
    .wdata (req_q.payload),
    .raddr (cons_ptr),
    .rdata (pl_rdata)
  );

  // notification coalescing, pending count saturates
  always_comb begin
    pend_inc = pend_writes;
    if (stored && pend_writes != PEND_MAX) begin
      pend_inc = pend_writes + CNT16_W'(1);
    end
    fire = (pend_inc >= notify_batch || min_interval == '0 || interval_ok) &&
           (pend_inc != '0 || interval_ok);
  end

  always_comb begin
    result_next = '0;
    any_fin     = ctl.offer_fin | ctl.take_fin | ctl.done_fin | ctl.query_fin;
    if (ctl.offer_fin) begin
      result_next.status = stored ? STS_OK : STS_FULL;
      result_next.notify = fire;
    end else if (ctl.take_fin) begin
      if (st_rdata == SS_PENDING) begin
        result_next.payload_res = pl_rdata;
        result_next.slot_res    = SLOT_W'(cons_ptr);
      end else begin
        result_next.status = STS_EMPTY;
      end
    end else if (ctl.done_fin) begin
      if (!(slot_in && st_rdata == SS_PENDING)) begin
        result_next.status = STS_IGNORED;
      end
    end else if (ctl.query_fin) begin
      if (slot_in) begin
        result_next.slot_state = st_rdata;
      end else begin
        result_next.status = STS_IGNORED;
      end
    end
  end

  assign stat.clean_more = (st_rdata == SS_CONSUMED) && (walk_cnt < ring_n);
  assign stat.cons_more  = (st_rdata == SS_CONSUMED) && (walk_cnt < ring_n);
  assign stat.clear_last = (clr_cnt == PW'(DEPTH - 1));
  assign stat.cmd        = req_q.command;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= RST_SLOTS_IN_USE;
      notify_batch <= RST_NOTIFY_BATCH;
      min_interval <= RST_MIN_INTERVAL;
      clean_ptr    <= '0;
      prod_ptr     <= '0;
      cons_ptr     <= '0;
      clr_cnt      <= '0;
      walk_cnt     <= '0;
      pend_writes  <= '0;
      last_time    <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SLOTS_IN_USE: slots_in_use <= SIU_W'(cfg_data);
          CFG_NOTIFY_BATCH: notify_batch <= cfg_data;
          CFG_MIN_INTERVAL: min_interval <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.clear_wr) begin
        clr_cnt <= clr_cnt + PW'(1);
      end
      if (ctl.load) begin
        walk_cnt <= '0;
        case (req.command)
          CMD_OFFER: begin
            clean_ptr <= fix_ptr(clean_ptr, ring_n);
            prod_ptr  <= fix_ptr(prod_ptr, ring_n);
          end
          CMD_TAKE: cons_ptr <= fix_ptr(cons_ptr, ring_n);
          default: ;
        endcase
      end
      if (ctl.clean_step) begin
        clean_ptr <= adv_ptr(clean_ptr, ring_n);
        walk_cnt  <= walk_cnt + NW'(1);
      end
      if (ctl.cons_step) begin
        cons_ptr <= adv_ptr(cons_ptr, ring_n);
        walk_cnt <= walk_cnt + NW'(1);
      end
      if (ctl.offer_fin) begin
        if (stored) begin
          prod_ptr <= adv_ptr(prod_ptr, ring_n);
        end
        pend_writes <= fire ? '0 : pend_inc;
        if (fire) begin
          last_time <= req_q.now_ms;
        end
      end
      if (ctl.take_fin && st_rdata == SS_PENDING) begin
        cons_ptr <= adv_ptr(cons_ptr, ring_n);
      end
    end
  end

  // request latch, interval check and result register
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q <= req;
    end
    interval_ok <= (req_q.now_ms - last_time) >= TIME_W'(min_interval);
    if (any_fin) begin
      result <= result_next;
    end
  end

endmodule

// File: rtl/ssrf_ctrl.sv
// sequencing state machine for the slot status ring fifo
module ssrf_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ssrf_pkg::CMD_W-1:0]  command,
  input  ssrf_pkg::dp_stat_t          stat,
  output logic                        busy,
  output logic                        result_valid,
  output ssrf_pkg::ctl_t              ctl
);
  import ssrf_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE, S_RESP: begin
        if (accept) begin
          case (command)
            CMD_OFFER: state_next = S_CLEAN_RD;
            CMD_TAKE:  state_next = S_CONS_RD;
            default:   state_next = S_SLOT_RD;
          endcase
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CLEAN_RD: state_next = S_CLEAN_EV;
      S_CLEAN_EV: state_next = stat.clean_more ? S_CLEAN_RD : S_PROD_RD;
      S_PROD_RD:  state_next = S_PROD_EV;
      S_PROD_EV:  state_next = S_RESP;
      S_CONS_RD:  state_next = S_CONS_EV;
      S_CONS_EV:  state_next = stat.cons_more ? S_CONS_RD : S_RESP;
      S_SLOT_RD:  state_next = S_SLOT_EV;
      S_SLOT_EV:  state_next = S_RESP;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl          = '0;
    ctl.rd_sel   = RA_SLOT;
    busy         = 1'b1;
    result_valid = 1'b0;
    case (state)
      S_CLEAR:    ctl.clear_wr = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = accept;
      end
      S_RESP: begin
        busy         = 1'b0;
        result_valid = 1'b1;
        ctl.load     = accept;
      end
      S_CLEAN_RD: ctl.rd_sel = RA_CLEAN;
      S_CLEAN_EV: ctl.clean_step = stat.clean_more;
      S_PROD_RD:  ctl.rd_sel = RA_PROD;
      S_PROD_EV:  ctl.offer_fin = 1'b1;
      S_CONS_RD:  ctl.rd_sel = RA_CONS;
      S_CONS_EV: begin
        ctl.cons_step = stat.cons_more;
        ctl.take_fin  = !stat.cons_more;
      end
      S_SLOT_RD:  ctl.rd_sel = RA_SLOT;
      S_SLOT_EV: begin
        ctl.done_fin  = (stat.cmd == CMD_DONE);
        ctl.query_fin = (stat.cmd != CMD_DONE);
      end
      default: ;
    endcase
  end

endmodule
